### hdl/tsd_pkg.sv
// Shared types, constants and helpers for the tar stream deframer.
// No dependencies; used by tsd_core, tsd_fifo and tar_stream_deframer_top.
`timescale 1ns / 1ps

package tsd_pkg;

  // archive geometry
  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned HDR_CNT_W   = $clog2(BLOCK_BYTES);
  localparam int unsigned SIZE_OFFSET = 124;
  localparam int unsigned SIZE_DIGITS = 11;
  localparam int unsigned OCT_W       = 3;
  localparam int unsigned SIZE_W      = SIZE_DIGITS * OCT_W;
  localparam int unsigned PAD_W       = SIZE_W + 1;

  // field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned ERR_W  = 2;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // ascii octal digits
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;

  typedef enum logic [CMD_W-1:0] {
    CMD_DATA    = 3'd0,
    CMD_EXTRACT = 3'd1,
    CMD_RECEIVE = 3'd2,
    CMD_SKIP    = 3'd3,
    CMD_CONT    = 3'd4
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 3'd0,
    KIND_RECV    = 3'd1,
    KIND_EXTR    = 3'd2,
    KIND_FEND    = 3'd3,
    KIND_AEND    = 3'd4,
    KIND_ERROR   = 3'd5,
    KIND_REFUSED = 3'd6
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_NAME  = 2'd1,
    ERR_SIZE  = 2'd2,
    ERR_STATE = 2'd3
  } err_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] payload;
    logic [SIZE_W-1:0] file_size;
    err_e              error_code;
    logic              last;
  } res_t;

  // results produced by one accepted item, slot 0 first
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } core_out_t;

  function automatic res_t mk_res(kind_e k, logic [BYTE_W-1:0] p,
                                  logic [SIZE_W-1:0] s, err_e e);
    res_t r;
    r.kind       = k;
    r.payload    = p;
    r.file_size  = s;
    r.error_code = e;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

### hdl/tar_stream_deframer_top.sv
// Top level of the tar stream deframer: parser core plus result queue.
// Depends on tsd_pkg, tsd_core and tsd_fifo.
`timescale 1ns / 1ps

// Usage
// - input channel: in_valid_i / in_stall_o carry cmd_i and data_byte_i; a data
//   byte or a decision/continue command moves in each transfer
// - output channel: out_valid_o / out_stall_i carry kind_o, payload_o,
//   file_size_o, error_code_o and last_o; last_o marks the final result of
//   the input item that caused it
// - an accepted item updates the parser state and its results are registered
//   into the result queue, behind any results already waiting
// - throughput is one item per cycle while in_stall_o is low; the final padded
//   byte of a file can cause two results (byte and file end), which leave in turn
// - results go through a four-entry queue; in_stall_o rises while the queue
//   holds three or more results, so a stalled receiver backs up the input
//   once three or four results are waiting
// - reset clears the parser to header collection and empties the queue
// - after an archive end or a header error the block keeps answering every
//   item with one refused or error result until the next reset
module tar_stream_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tsd_pkg::CMD_W-1:0]   cmd_i,
  input  logic [tsd_pkg::BYTE_W-1:0]  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tsd_pkg::KIND_W-1:0]  kind_o,
  output logic [tsd_pkg::BYTE_W-1:0]  payload_o,
  output logic [tsd_pkg::SIZE_W-1:0]  file_size_o,
  output logic [tsd_pkg::ERR_W-1:0]   error_code_o,
  output logic                        last_o
);

  localparam logic [tsd_pkg::FIFO_CNT_W-1:0] StallLevel =
    tsd_pkg::FIFO_CNT_W'(tsd_pkg::FIFO_DEPTH - 1);

  logic                             in_xfer;
  logic                             out_xfer;
  tsd_pkg::core_out_t               core_out;
  tsd_pkg::res_t                    head;
  logic [tsd_pkg::FIFO_CNT_W-1:0]   fill;

  // handshakes
  assign in_stall_o = (fill >= StallLevel);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_o & ~out_stall_i;

  // parser
  tsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .out_o       (core_out)
  );

  // result queue
  tsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_out),
    .pop_i   (out_xfer),
    .valid_o (out_valid_o),
    .head_o  (head),
    .count_o (fill)
  );

  // output fields
  assign kind_o       = head.kind;
  assign payload_o    = head.payload;
  assign file_size_o  = head.file_size;
  assign error_code_o = head.error_code;
  assign last_o       = head.last;

  // checks
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_out.n == 2'd2 |-> !core_out.r0.last && core_out.r1.last &&
                           core_out.r1.kind == tsd_pkg::KIND_FEND)
    else $error("two results without trailing file end");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= tsd_pkg::FIFO_CNT_W'(tsd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_refused_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == tsd_pkg::KIND_REFUSED |->
      error_code_o == tsd_pkg::ERR_STATE && last_o)
    else $error("refused result with wrong code");

  a_start_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == tsd_pkg::KIND_START |->
      file_size_o != '0 && error_code_o == tsd_pkg::ERR_NONE)
    else $error("file start without size");

endmodule

### hdl/tsd_core.sv
// Deframer state machine: header collection, size parsing, payload passing.
// Depends on tsd_pkg; produces up to two results per accepted item.
`timescale 1ns / 1ps

module tsd_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [tsd_pkg::CMD_W-1:0]  cmd_i,
  input  logic [tsd_pkg::BYTE_W-1:0] data_byte_i,
  output tsd_pkg::core_out_t         out_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_DECIDE,
    PH_EXTRACT,
    PH_RECEIVE,
    PH_SKIP,
    PH_CONTINUE,
    PH_HALTED,
    PH_ENDED
  } phase_e;

  localparam logic [tsd_pkg::HDR_CNT_W-1:0] HdrLast =
    tsd_pkg::HDR_CNT_W'(tsd_pkg::BLOCK_BYTES - 1);
  localparam logic [tsd_pkg::HDR_CNT_W-1:0] SizeFirst =
    tsd_pkg::HDR_CNT_W'(tsd_pkg::SIZE_OFFSET);
  localparam logic [tsd_pkg::HDR_CNT_W-1:0] SizeEnd =
    tsd_pkg::HDR_CNT_W'(tsd_pkg::SIZE_OFFSET + tsd_pkg::SIZE_DIGITS);
  localparam int unsigned BlkHiW = tsd_pkg::SIZE_W - tsd_pkg::HDR_CNT_W;

  phase_e                           phase_q, phase_d;
  logic [tsd_pkg::HDR_CNT_W-1:0]    hdr_cnt_q, hdr_cnt_d;
  logic                             all_zero_q, all_zero_d;
  logic                             name_empty_q, name_empty_d;
  logic [tsd_pkg::SIZE_W-1:0]       size_acc_q, size_acc_d;
  logic                             size_bad_q, size_bad_d;
  logic [tsd_pkg::PAD_W-1:0]        pad_rem_q, pad_rem_d;
  logic [tsd_pkg::SIZE_W-1:0]       file_rem_q, file_rem_d;

  // header byte update terms
  logic                             in_size;
  logic                             digit_ok;
  logic [tsd_pkg::SIZE_W-1:0]       acc_nx;
  logic                             az_nx, ne_nx, bad_nx;
  logic [tsd_pkg::PAD_W-1:0]        padded;
  logic [tsd_pkg::PAD_W-1:0]        pad_dec;
  logic                             byte_emit, fend_emit;
  tsd_pkg::res_t                    byte_res;

  assign in_size  = (hdr_cnt_q >= SizeFirst) && (hdr_cnt_q < SizeEnd);
  assign digit_ok = (data_byte_i >= tsd_pkg::CHAR_ZERO) &&
                    (data_byte_i <= tsd_pkg::CHAR_SEVEN);
  assign acc_nx   = (in_size && digit_ok) ?
                    {size_acc_q[tsd_pkg::SIZE_W-tsd_pkg::OCT_W-1:0],
                     data_byte_i[tsd_pkg::OCT_W-1:0]} : size_acc_q;
  assign bad_nx   = size_bad_q | (in_size & ~digit_ok);
  assign az_nx    = all_zero_q & (data_byte_i == '0);
  assign ne_nx    = (hdr_cnt_q == '0) ? (data_byte_i == '0) : name_empty_q;

  // size rounded up to a whole block
  assign padded = {{1'b0, acc_nx[tsd_pkg::SIZE_W-1:tsd_pkg::HDR_CNT_W]}
                   + (BlkHiW + 1)'(acc_nx[tsd_pkg::HDR_CNT_W-1:0] != '0),
                   tsd_pkg::HDR_CNT_W'(0)};
  assign pad_dec = (pad_rem_q != '0) ? pad_rem_q - 1'b1 : pad_rem_q;

  // next state and results
  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    all_zero_d   = all_zero_q;
    name_empty_d = name_empty_q;
    size_acc_d   = size_acc_q;
    size_bad_d   = size_bad_q;
    pad_rem_d    = pad_rem_q;
    file_rem_d   = file_rem_q;
    byte_emit    = 1'b0;
    fend_emit    = 1'b0;
    byte_res     = tsd_pkg::mk_res(tsd_pkg::KIND_RECV, data_byte_i, '0,
                                   tsd_pkg::ERR_NONE);
    out_o.n      = 2'd0;
    out_o.r0     = tsd_pkg::mk_res(tsd_pkg::KIND_REFUSED, '0, '0, tsd_pkg::ERR_STATE);
    out_o.r1     = tsd_pkg::mk_res(tsd_pkg::KIND_FEND, '0, '0, tsd_pkg::ERR_NONE);

    if (accept_i) begin
      priority if (phase_q == PH_HALTED) begin
        out_o.n  = 2'd1;
        out_o.r0 = tsd_pkg::mk_res(tsd_pkg::KIND_ERROR, '0, '0,
                                   name_empty_q ? tsd_pkg::ERR_NAME : tsd_pkg::ERR_SIZE);
      end else if (phase_q == PH_ENDED) begin
        out_o.n = 2'd1;
      end else begin
        unique case (tsd_pkg::cmd_e'(cmd_i))
          tsd_pkg::CMD_DATA: begin
            if (phase_q == PH_HEADER) begin
              all_zero_d   = az_nx;
              name_empty_d = ne_nx;
              size_acc_d   = acc_nx;
              size_bad_d   = bad_nx;
              if (hdr_cnt_q != HdrLast) begin
                hdr_cnt_d = hdr_cnt_q + 1'b1;
              end else begin
                hdr_cnt_d = '0;
                out_o.n   = 2'd1;
                priority if (az_nx) begin
                  phase_d  = PH_ENDED;
                  out_o.r0 = tsd_pkg::mk_res(tsd_pkg::KIND_AEND, '0, '0,
                                             tsd_pkg::ERR_NONE);
                end else if (ne_nx) begin
                  phase_d  = PH_HALTED;
                  out_o.r0 = tsd_pkg::mk_res(tsd_pkg::KIND_ERROR, '0, '0,
                                             tsd_pkg::ERR_NAME);
                end else if (bad_nx || acc_nx == '0) begin
                  phase_d  = PH_HALTED;
                  out_o.r0 = tsd_pkg::mk_res(tsd_pkg::KIND_ERROR, '0, '0,
                                             tsd_pkg::ERR_SIZE);
                end else begin
                  phase_d    = PH_DECIDE;
                  file_rem_d = acc_nx;
                  pad_rem_d  = padded;
                  out_o.r0   = tsd_pkg::mk_res(tsd_pkg::KIND_START, '0, acc_nx,
                                               tsd_pkg::ERR_NONE);
                end
              end
            end else if (phase_q == PH_EXTRACT || phase_q == PH_RECEIVE ||
                         phase_q == PH_SKIP) begin
              if (file_rem_q != '0) begin
                file_rem_d = file_rem_q - 1'b1;
                byte_emit  = (phase_q != PH_SKIP);
                if (phase_q == PH_EXTRACT) begin
                  byte_res.kind = tsd_pkg::KIND_EXTR;
                end
              end
              pad_rem_d = pad_dec;
              if (pad_dec == '0) begin
                phase_d   = PH_CONTINUE;
                fend_emit = 1'b1;
              end
              // pack byte and file end into the result slots
              if (byte_emit) begin
                out_o.r0 = byte_res;
                out_o.n  = fend_emit ? 2'd2 : 2'd1;
              end else if (fend_emit) begin
                out_o.r0 = out_o.r1;
                out_o.n  = 2'd1;
              end
            end else begin
              out_o.n = 2'd1;
            end
          end
          tsd_pkg::CMD_EXTRACT, tsd_pkg::CMD_RECEIVE, tsd_pkg::CMD_SKIP: begin
            if (phase_q == PH_DECIDE) begin
              unique case (tsd_pkg::cmd_e'(cmd_i))
                tsd_pkg::CMD_EXTRACT: phase_d = PH_EXTRACT;
                tsd_pkg::CMD_RECEIVE: phase_d = PH_RECEIVE;
                default:              phase_d = PH_SKIP;
              endcase
            end else begin
              out_o.n = 2'd1;
            end
          end
          tsd_pkg::CMD_CONT: begin
            if (phase_q == PH_CONTINUE) begin
              phase_d      = PH_HEADER;
              hdr_cnt_d    = '0;
              all_zero_d   = 1'b1;
              name_empty_d = 1'b0;
              size_acc_d   = '0;
              size_bad_d   = 1'b0;
            end else begin
              out_o.n = 2'd1;
            end
          end
          default: begin
            out_o.n = 2'd1;
          end
        endcase
      end
    end

    // mark the final result of this item
    if (out_o.n == 2'd1) begin
      out_o.r0.last = 1'b1;
    end
    if (out_o.n == 2'd2) begin
      out_o.r1.last = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      hdr_cnt_q    <= '0;
      all_zero_q   <= 1'b1;
      name_empty_q <= 1'b0;
      size_acc_q   <= '0;
      size_bad_q   <= 1'b0;
      pad_rem_q    <= '0;
      file_rem_q   <= '0;
    end else begin
      phase_q      <= phase_d;
      hdr_cnt_q    <= hdr_cnt_d;
      all_zero_q   <= all_zero_d;
      name_empty_q <= name_empty_d;
      size_acc_q   <= size_acc_d;
      size_bad_q   <= size_bad_d;
      pad_rem_q    <= pad_rem_d;
      file_rem_q   <= file_rem_d;
    end
  end

endmodule

### hdl/tsd_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on tsd_pkg for the result type and queue depth.
`timescale 1ns / 1ps

module tsd_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsd_pkg::core_out_t            push_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output tsd_pkg::res_t                 head_o,
  output logic [tsd_pkg::FIFO_CNT_W-1:0] count_o
);

  tsd_pkg::res_t                    mem_q [tsd_pkg::FIFO_DEPTH];
  logic [tsd_pkg::FIFO_PTR_W-1:0]   wr_q, rd_q;
  logic [tsd_pkg::FIFO_CNT_W-1:0]   cnt_q;
  logic [tsd_pkg::FIFO_PTR_W-1:0]   wr_nx;

  assign wr_nx   = wr_q + 1'b1;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nx] <= push_i.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + tsd_pkg::FIFO_PTR_W'(push_i.n);
      rd_q  <= rd_q + tsd_pkg::FIFO_PTR_W'(pop_i);
      cnt_q <= cnt_q + tsd_pkg::FIFO_CNT_W'(push_i.n) - tsd_pkg::FIFO_CNT_W'(pop_i);
    end
  end

endmodule

### tb/tar_deframe_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the tar stream deframer: mirrors the archive parser, queues
// the results each input transfer should cause and compares every output transfer.
// Depends on tsd_pkg.

module tar_deframe_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [tsd_pkg::CMD_W-1:0]  cmd_i,
  input  logic [tsd_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [tsd_pkg::KIND_W-1:0] kind_i,
  input  logic [tsd_pkg::BYTE_W-1:0] payload_i,
  input  logic [tsd_pkg::SIZE_W-1:0] file_size_i,
  input  logic [tsd_pkg::ERR_W-1:0]  error_code_i,
  input  logic                       last_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  import tsd_pkg::*;

  typedef enum logic [2:0] {
    AT_HEADER,
    AT_DECISION,
    IN_EXTRACT,
    IN_RECEIVE,
    IN_SKIP,
    AT_CONTINUE,
    HALTED,
    ENDED
  } arc_phase_e;

  localparam logic [PAD_W-1:0] BLK_MASK = PAD_W'(BLOCK_BYTES - 1);

  // mirrored parser state
  arc_phase_e             arc_phase;
  logic [HDR_CNT_W-1:0]   hdr_idx;
  logic                   hdr_zero;
  logic                   name_blank;
  logic [SIZE_W-1:0]      size_acc;
  logic                   size_fault;
  logic [PAD_W-1:0]       pad_left;
  logic [SIZE_W-1:0]      body_left;

  // results still owed by the block, oldest first
  res_t                   deframe_out_q[$];
  res_t                   want_res;
  int                     mismatches;

  function automatic void restart_header();
    hdr_idx    = '0;
    hdr_zero   = 1'b1;
    name_blank = 1'b0;
    size_acc   = '0;
    size_fault = 1'b0;
  endfunction

  function automatic void add_res(kind_e k, logic [BYTE_W-1:0] p, logic [SIZE_W-1:0] s,
                                  err_e e);
    res_t r;
    r.kind       = k;
    r.payload    = p;
    r.file_size  = s;
    r.error_code = e;
    r.last       = 1'b0;
    deframe_out_q.push_back(r);
  endfunction

  function automatic bit field_ok(input string fname, input logic [SIZE_W-1:0] want,
                                  input logic [SIZE_W-1:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
    return 1'b0;
  endfunction

  // next state and results of one accepted item
  task automatic deframe_step(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    int   owed_before;
    res_t r;
    owed_before = deframe_out_q.size();
    if (arc_phase == HALTED) begin
      add_res(KIND_ERROR, '0, '0, name_blank ? ERR_NAME : ERR_SIZE);
    end else if (arc_phase == ENDED) begin
      add_res(KIND_REFUSED, '0, '0, ERR_STATE);
    end else if (c == CMD_DATA) begin
      case (arc_phase)
        AT_HEADER: begin
          if (b != 0) hdr_zero = 1'b0;
          if (hdr_idx == 0) name_blank = (b == 0);
          if (hdr_idx >= SIZE_OFFSET && hdr_idx < SIZE_OFFSET + SIZE_DIGITS) begin
            if (b >= CHAR_ZERO && b <= CHAR_SEVEN)
              size_acc = {size_acc[SIZE_W-OCT_W-1:0], b[OCT_W-1:0]};
            else
              size_fault = 1'b1;
          end
          if (hdr_idx != BLOCK_BYTES - 1) begin
            hdr_idx = hdr_idx + 1'b1;
          end else begin
            hdr_idx = '0;
            // whole header seen: archive end, fault or a new file
            if (hdr_zero) begin
              arc_phase = ENDED;
              add_res(KIND_AEND, '0, '0, ERR_NONE);
            end else if (name_blank) begin
              arc_phase = HALTED;
              add_res(KIND_ERROR, '0, '0, ERR_NAME);
            end else if (size_fault || size_acc == 0) begin
              arc_phase = HALTED;
              add_res(KIND_ERROR, '0, '0, ERR_SIZE);
            end else begin
              body_left = size_acc;
              pad_left  = ({1'b0, size_acc} + BLK_MASK) & ~BLK_MASK;
              arc_phase = AT_DECISION;
              add_res(KIND_START, '0, size_acc, ERR_NONE);
            end
          end
        end
        IN_EXTRACT, IN_RECEIVE, IN_SKIP: begin
          if (body_left != 0) begin
            body_left = body_left - 1'b1;
            if (arc_phase == IN_EXTRACT) add_res(KIND_EXTR, b, '0, ERR_NONE);
            else if (arc_phase == IN_RECEIVE) add_res(KIND_RECV, b, '0, ERR_NONE);
          end
          if (pad_left != 0) pad_left = pad_left - 1'b1;
          if (pad_left == 0) begin
            arc_phase = AT_CONTINUE;
            add_res(KIND_FEND, '0, '0, ERR_NONE);
          end
        end
        default: add_res(KIND_REFUSED, '0, '0, ERR_STATE);
      endcase
    end else if ((c == CMD_EXTRACT || c == CMD_RECEIVE || c == CMD_SKIP) &&
                 arc_phase == AT_DECISION) begin
      if (c == CMD_EXTRACT) arc_phase = IN_EXTRACT;
      else if (c == CMD_RECEIVE) arc_phase = IN_RECEIVE;
      else arc_phase = IN_SKIP;
    end else if (c == CMD_CONT && arc_phase == AT_CONTINUE) begin
      arc_phase = AT_HEADER;
      restart_header();
    end else begin
      add_res(KIND_REFUSED, '0, '0, ERR_STATE);
    end
    // flag the final result of this item
    if (deframe_out_q.size() > owed_before) begin
      r = deframe_out_q.pop_back();
      r.last = 1'b1;
      deframe_out_q.push_back(r);
    end
  endtask

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_phase = AT_HEADER;
      restart_header();
      pad_left  = '0;
      body_left = '0;
      deframe_out_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (deframe_out_q.size() == 0) begin
          mismatches++;
          $display("%0t: result kind %0d arrived, none expected", $time, kind_i);
        end else begin
          want_res = deframe_out_q.pop_front();
          if (!(field_ok("kind", SIZE_W'(want_res.kind), SIZE_W'(kind_i)) &
                field_ok("payload", SIZE_W'(want_res.payload), SIZE_W'(payload_i)) &
                field_ok("file_size", want_res.file_size, file_size_i) &
                field_ok("error_code", SIZE_W'(want_res.error_code),
                         SIZE_W'(error_code_i)) &
                field_ok("last", SIZE_W'(want_res.last), SIZE_W'(last_i))))
            mismatches++;
        end
      end
      if (in_valid_i && !in_stall_i) deframe_step(cmd_i, data_byte_i);
      fail_count_o <= mismatches;
      pending_o    <= deframe_out_q.size();
    end
  end

endmodule

### tb/tar_stream_deframer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the tar stream deframer: builds archives of several files
// with stray commands mixed in and gives the verdict. Depends on tsd_pkg,
// tar_stream_deframer_top and tar_deframe_checker.

module tar_stream_deframer_top_tb;

  import tsd_pkg::*;

  localparam int IDLE_PCT     = 22;
  localparam int STRAY_PCT    = 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_FILES = 6;
  localparam int TAIL_ITEMS   = 40;
  localparam int OPEN_BYTES   = 30;

  // header flavors
  localparam int HDR_OCTAL    = 0;
  localparam int HDR_NONOCTAL = 1;
  localparam int HDR_ALLZERO  = 2;

  // ways the archive can stop
  localparam int END_ZERO_BLOCK = 0;
  localparam int END_BLANK_NAME = 1;
  localparam int END_BAD_DIGIT  = 2;
  localparam int END_ZERO_SIZE  = 3;
  localparam int END_OPEN_FILE  = 4;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd;
  logic [BYTE_W-1:0]   data_b;
  logic                out_valid;
  logic                out_stall;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   payload;
  logic [SIZE_W-1:0]   file_size;
  logic [ERR_W-1:0]    error_code;
  logic                last;
  logic                calm;
  logic                squeeze_go;
  int                  fail_count;
  int                  pending;

  tar_stream_deframer_top uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .data_byte_i  (data_b),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .payload_o    (payload),
    .file_size_o  (file_size),
    .error_code_o (error_code),
    .last_o       (last)
  );

  tar_deframe_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .data_byte_i  (data_b),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .kind_i       (kind),
    .payload_i    (payload),
    .file_size_i  (file_size),
    .error_code_i (error_code),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    data_b   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // one random command that is wrong outside the lo..hi range
  task automatic send_stray(input logic [CMD_W-1:0] lo, input logic [CMD_W-1:0] hi);
    logic [CMD_W-1:0] c;
    c = CMD_W'($urandom_range((1 << CMD_W) - 1));
    while (c >= lo && c <= hi) c = CMD_W'($urandom_range((1 << CMD_W) - 1));
    send_item(c, BYTE_W'($urandom_range(255)));
  endtask

  // every command outside lo..hi once
  task automatic send_all_wrong(input logic [CMD_W-1:0] lo, input logic [CMD_W-1:0] hi);
    int c;
    for (c = 0; c < (1 << CMD_W); c++)
      if (c < lo || c > hi) send_item(CMD_W'(c), BYTE_W'($urandom_range(255)));
  endtask

  task automatic send_header(input logic [BYTE_W-1:0] name0, input logic [SIZE_W-1:0] fsize,
                             input int mode);
    int                i;
    int                bad_at;
    logic [BYTE_W-1:0] v;
    bad_at = $urandom_range(SIZE_OFFSET + SIZE_DIGITS - 1, SIZE_OFFSET);
    for (i = 0; i < BLOCK_BYTES; i++) begin
      if (mode == HDR_ALLZERO) begin
        v = '0;
      end else if (i == 0) begin
        v = name0;
      end else if (i >= SIZE_OFFSET && i < SIZE_OFFSET + SIZE_DIGITS) begin
        // size digits, most significant first
        v = CHAR_ZERO + fsize[(SIZE_OFFSET + SIZE_DIGITS - 1 - i) * OCT_W +: OCT_W];
        if (mode == HDR_NONOCTAL && i == bad_at) begin
          if ($urandom_range(1)) v = BYTE_W'($urandom_range(CHAR_ZERO - 1));
          else v = BYTE_W'($urandom_range(255, CHAR_SEVEN + 1));
        end
      end else if ($urandom_range(1)) begin
        v = '0;
      end else begin
        v = BYTE_W'($urandom_range(255));
      end
      if ($urandom_range(99) < STRAY_PCT) send_stray(CMD_DATA, CMD_DATA);
      send_item(CMD_DATA, v);
    end
  endtask

  // header, decision, padded body and continue for one file
  task automatic run_file(input logic [SIZE_W-1:0] fsize, input logic [CMD_W-1:0] pick,
                          input bit sweep, input bit squeeze);
    logic [PAD_W-1:0] padded;
    int               n;
    padded = ({1'b0, fsize} + PAD_W'(BLOCK_BYTES - 1)) & ~(PAD_W'(BLOCK_BYTES - 1));
    send_header(BYTE_W'($urandom_range(255, 1)), fsize, HDR_OCTAL);
    if (sweep) send_all_wrong(CMD_EXTRACT, CMD_SKIP);
    else repeat ($urandom_range(2)) send_stray(CMD_EXTRACT, CMD_SKIP);
    send_item(pick, BYTE_W'($urandom_range(255)));
    if (squeeze) squeeze_go <= 1'b1;
    for (n = 0; n < padded; n++) begin
      if (sweep && n == 0) send_all_wrong(CMD_DATA, CMD_DATA);
      else if ($urandom_range(99) < STRAY_PCT) send_stray(CMD_DATA, CMD_DATA);
      if (n == 0) send_item(CMD_DATA, 8'hFF);
      else if (n == 1) send_item(CMD_DATA, 8'h00);
      else send_item(CMD_DATA, BYTE_W'($urandom_range(255)));
    end
    if (sweep) send_all_wrong(CMD_CONT, CMD_CONT);
    else repeat ($urandom_range(2)) send_stray(CMD_CONT, CMD_CONT);
    send_item(CMD_CONT, BYTE_W'($urandom_range(255)));
  endtask

  // receiver: random stalls, one long hold-off once asked
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (squeeze_go) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        wait (!squeeze_go);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [SIZE_W-1:0] fsize;
    int                k;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    cmd        <= CMD_DATA;
    data_b     <= '0;
    calm       <= 1'b0;
    squeeze_go <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // wrong commands while collecting a header, then the smallest file
    send_all_wrong(CMD_DATA, CMD_DATA);
    run_file(SIZE_W'(1), CMD_EXTRACT, 1'b1, 1'b0);

    // exactly one block of payload, no idling on either side
    calm <= 1'b1;
    run_file(SIZE_W'(BLOCK_BYTES), CMD_RECEIVE, 1'b0, 1'b0);
    calm <= 1'b0;

    // receiver holds off while a two-block file streams in
    run_file(SIZE_W'(BLOCK_BYTES + 1), CMD_RECEIVE, 1'b0, 1'b1);
    squeeze_go <= 1'b0;

    for (k = 0; k < RANDOM_FILES; k++) begin
      if ($urandom_range(5) == 0)
        fsize = SIZE_W'($urandom_range(4 * BLOCK_BYTES, BLOCK_BYTES));
      else
        fsize = SIZE_W'($urandom_range(BLOCK_BYTES + 200, 1));
      run_file(fsize, CMD_W'($urandom_range(CMD_SKIP, CMD_EXTRACT)), 1'b0, 1'b0);
    end

    // close the archive one way or another
    case ($urandom_range(END_OPEN_FILE))
      END_ZERO_BLOCK: send_header('0, '0, HDR_ALLZERO);
      END_BLANK_NAME:
        send_header('0, SIZE_W'($urandom_range(9999, 1)),
                    $urandom_range(1) ? HDR_NONOCTAL : HDR_OCTAL);
      END_BAD_DIGIT:
        send_header(BYTE_W'($urandom_range(255, 1)), SIZE_W'($urandom_range(9999, 1)),
                    HDR_NONOCTAL);
      END_ZERO_SIZE: send_header(BYTE_W'($urandom_range(255, 1)), '0, HDR_OCTAL);
      default: begin
        send_header(BYTE_W'($urandom_range(255, 1)), '1, HDR_OCTAL);
        send_item(CMD_W'($urandom_range(CMD_SKIP, CMD_EXTRACT)),
                  BYTE_W'($urandom_range(255)));
        repeat (OPEN_BYTES) send_item(CMD_DATA, BYTE_W'($urandom_range(255)));
      end
    endcase

    // items after the end get refused or errored, or pass as body bytes of an open file
    repeat (TAIL_ITEMS)
      send_item(CMD_W'($urandom_range((1 << CMD_W) - 1)), BYTE_W'($urandom_range(255)));
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
